### sv/garm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the generational address range map.
// No dependencies; every other file of the block refers to it by scoped names.
package garm_pkg;

    localparam int GEN_W  = 4;
    localparam int ADDR_W = 64;
    localparam int SIZE_W = 32;
    localparam int CODE_W = 16;
    localparam int ST_W   = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [ST_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [ST_W-1:0] ST_HIT      = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS     = 2'd3;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CODE_W-1:0] code;
    } t_range;

    // Candidate update sent from the scan to the per-generation store.
    typedef struct packed {
        logic   valid;
        t_range ent;
    } t_cand_upd;

    typedef struct packed {
        logic clear;
        logic pick;
    } t_cand_ctl;

    typedef struct packed {
        logic busy;
        logic have;
    } t_cand_sts;

endpackage

### sv/garm_req_if.sv
`timescale 1ns / 1ps
// Request channel of the generational address range map.
// Depends on garm_pkg for the field widths.
interface garm_req_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [garm_pkg::GEN_W-1:0]     entry_gen;
    logic [garm_pkg::ADDR_W-1:0]    entry_base;
    logic [garm_pkg::SIZE_W-1:0]    entry_size;
    logic [garm_pkg::CODE_W-1:0]    entry_code;
    logic [garm_pkg::ADDR_W-1:0]    lookup_address;

    modport source (
        output valid, cmd, entry_gen, entry_base, entry_size, entry_code, lookup_address,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_gen, entry_base, entry_size, entry_code, lookup_address,
        output ready
    );
endinterface

### sv/garm_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the generational address range map.
// Depends on garm_pkg for the field widths.
interface garm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [garm_pkg::ST_W-1:0]      status;
    logic [garm_pkg::CODE_W-1:0]    code;
    logic [garm_pkg::SIZE_W-1:0]    offset;
    logic [garm_pkg::GEN_W-1:0]     found_gen;

    modport source (
        output valid, status, code, offset, found_gen,
        input  ready
    );
    modport sink (
        input  valid, status, code, offset, found_gen,
        output ready
    );
endinterface

### sv/garm_table.sv
`timescale 1ns / 1ps
// Range table: one synchronous memory of placed ranges, one write and one read port.
// Depends on garm_pkg for the range type.
module garm_table #(
    parameter int ENTRIES   = 64,
    parameter int CODE_BITS = 16,
    localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_idx,
    input  garm_pkg::t_range       i_wr_data,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_idx,
    output garm_pkg::t_range       o_rd_data
);
    localparam int SW = (CODE_BITS < garm_pkg::CODE_W) ? CODE_BITS : garm_pkg::CODE_W;
    localparam int RW = garm_pkg::GEN_W + garm_pkg::ADDR_W + garm_pkg::SIZE_W + SW;
    localparam int CODE_W = garm_pkg::CODE_W;

    logic [RW-1:0] r_mem [ENTRIES];
    logic [RW-1:0] r_rd;

    // Only the low CODE_BITS of the code id are kept, at most all CODE_W bits.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_data.gen, i_wr_data.base, i_wr_data.size,
                                i_wr_data.code[SW-1:0]};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data.gen  = r_rd[RW-1 -: garm_pkg::GEN_W];
    assign o_rd_data.base = r_rd[SW+garm_pkg::SIZE_W +: garm_pkg::ADDR_W];
    assign o_rd_data.size = r_rd[SW +: garm_pkg::SIZE_W];
    assign o_rd_data.code = CODE_W'(r_rd[SW-1:0]);

endmodule

### sv/garm_cand.sv
`timescale 1ns / 1ps
// Per-generation candidate store: best range seen so far in each generation during a scan.
// Read-modify-write on a synchronous memory with forwarding; depends on garm_pkg.
module garm_cand #(
    parameter int GENERATIONS = 16,
    localparam int GW         = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  garm_pkg::t_cand_ctl    i_ctl,
    input  garm_pkg::t_cand_upd    i_upd,
    input  logic [GW-1:0]          i_pick_gen,
    output garm_pkg::t_cand_sts    o_sts,
    output garm_pkg::t_range       o_data
);
    garm_pkg::t_range r_mem [GENERATIONS];
    garm_pkg::t_range r_rd;
    garm_pkg::t_range r_sent;
    garm_pkg::t_range r_lwd;
    garm_pkg::t_range w_old;
    logic [GENERATIONS-1:0] r_have;
    logic [GW-1:0]          r_sg;
    logic [GW-1:0]          r_lwg;
    logic [GW-1:0]          w_ug;
    logic [GW-1:0]          w_rd_gen;
    logic                   w_rd_en;
    logic                   r_sv;
    logic                   r_lwv;
    logic                   r_phave;
    logic                   w_we;

    assign w_ug     = GW'(i_upd.ent.gen);
    assign w_rd_gen = i_upd.valid ? w_ug : i_pick_gen;
    assign w_rd_en  = i_upd.valid || i_ctl.pick;

    // The write of the previous cycle is not yet visible in the read data.
    assign w_old = (r_lwv && (r_lwg == r_sg)) ? r_lwd : r_rd;
    // On equal bases the later entry replaces the earlier one.
    assign w_we  = r_sv && (!r_have[r_sg] || (r_sent.base >= w_old.base));

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_gen];
        end
        if (w_we) begin
            r_mem[r_sg] <= r_sent;
        end
        r_sent <= i_upd.ent;
        r_sg   <= w_ug;
        r_lwg  <= r_sg;
        r_lwd  <= r_sent;
        if (i_ctl.pick) begin
            r_phave <= r_have[i_pick_gen];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv   <= 1'b0;
            r_lwv  <= 1'b0;
            r_have <= '0;
        end else begin
            r_sv  <= i_upd.valid;
            r_lwv <= w_we;
            if (i_ctl.clear) begin
                r_have <= '0;
            end else if (w_we) begin
                r_have[r_sg] <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_sv;
    assign o_sts.have = r_phave;
    assign o_data     = r_rd;

endmodule

### sv/generational_address_range_map.sv
`timescale 1ns / 1ps
// Insert: one request at a time; the result is registered, then moves to the output register once that is free.
// Lookup: for N stored ranges, one table memory read per range, then one candidate memory
// read per generation from newest down, stopping at a hit.
// One request is in work at a time; a new one is accepted while a result waits to be taken.
// Synchronous active-low reset empties the table and clears the candidate flags at once.
module generational_address_range_map #(
    parameter int ENTRIES     = 64,
    parameter int GENERATIONS = 16,
    parameter int CODE_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    garm_req_if.sink        i_req,
    garm_rsp_if.source      o_rsp
);
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int GW     = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1;
    localparam int GEN_W  = garm_pkg::GEN_W;
    localparam int ADDR_W = garm_pkg::ADDR_W;
    localparam int SIZE_W = garm_pkg::SIZE_W;
    localparam int CODE_W = garm_pkg::CODE_W;
    localparam int ST_W   = garm_pkg::ST_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_s1;
    logic [GW-1:0]      r_pg;
    logic [GW-1:0]      r_pe;
    logic               r_more;
    logic               r_pv;

    logic [ST_W-1:0]    r_rs_status;
    logic [CODE_W-1:0]  r_rs_code;
    logic [SIZE_W-1:0]  r_rs_offset;
    logic [GEN_W-1:0]   r_rs_gen;

    logic               r_ov;
    logic [ST_W-1:0]    r_o_status;
    logic [CODE_W-1:0]  r_o_code;
    logic [SIZE_W-1:0]  r_o_offset;
    logic [GEN_W-1:0]   r_o_gen;

    logic               w_acc;
    logic               w_full;
    logic               w_gen_ok;
    logic               w_ins_ok;
    logic               w_tbl_rd;
    logic               w_pick;
    logic               w_hit;
    logic               w_out_free;
    logic [ADDR_W-1:0]  w_diff;

    garm_pkg::t_range    w_wr_ent;
    garm_pkg::t_range    w_tbl_data;
    garm_pkg::t_range    w_cand_data;
    garm_pkg::t_cand_upd w_upd;
    garm_pkg::t_cand_ctl w_ctl;
    garm_pkg::t_cand_sts w_sts;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(ENTRIES));
    assign w_gen_ok    = int'(i_req.entry_gen) < GENERATIONS;
    assign w_ins_ok    = w_acc && (i_req.cmd == garm_pkg::CMD_INSERT) && !w_full && w_gen_ok;
    assign w_tbl_rd    = (r_state == S_SCAN) && (r_ptr != r_count);
    assign w_pick      = (r_state == S_PICK) && r_more;
    assign w_out_free  = !r_ov || o_rsp.ready;

    assign w_wr_ent.gen  = i_req.entry_gen;
    assign w_wr_ent.base = i_req.entry_base;
    assign w_wr_ent.size = i_req.entry_size;
    assign w_wr_ent.code = i_req.entry_code;

    garm_table #(
        .ENTRIES   (ENTRIES),
        .CODE_BITS (CODE_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_ins_ok),
        .i_wr_idx  (r_count[AW-1:0]),
        .i_wr_data (w_wr_ent),
        .i_rd_en   (w_tbl_rd),
        .i_rd_idx  (r_ptr[AW-1:0]),
        .o_rd_data (w_tbl_data)
    );

    // Only ranges that start at or below the address can be candidates.
    assign w_upd.valid = r_s1 && (w_tbl_data.base <= r_addr);
    assign w_upd.ent   = w_tbl_data;
    assign w_ctl.clear = w_acc && (i_req.cmd == garm_pkg::CMD_LOOKUP);
    assign w_ctl.pick  = w_pick;

    garm_cand #(
        .GENERATIONS (GENERATIONS)
    ) u_cand (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_upd      (w_upd),
        .i_pick_gen (r_pg),
        .o_sts      (w_sts),
        .o_data     (w_cand_data)
    );

    // The difference must fit in 32 bits and stay below the size; this covers the
    // unwrapped base plus size bound.
    assign w_diff = r_addr - w_cand_data.base;
    assign w_hit  = w_sts.have && (w_diff[ADDR_W-1:SIZE_W] == '0)
                    && (w_diff[SIZE_W-1:0] < w_cand_data.size);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (i_req.cmd == garm_pkg::CMD_INSERT) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ptr == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s1 && !w_sts.busy) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_pv && (w_hit || (r_pe == '0))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_s1    <= 1'b0;
            r_more  <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= w_tbl_rd;
            r_pv    <= w_pick;
            if (w_ins_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (w_ctl.clear) begin
                r_ptr <= '0;
            end else if (w_tbl_rd) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (r_state == S_DRAIN) begin
                r_more <= 1'b1;
            end else if (w_pick && (r_pg == '0)) begin
                r_more <= 1'b0;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_addr <= i_req.lookup_address;
        end
        // Generations are read from newest down, one per cycle.
        if (r_state == S_DRAIN) begin
            r_pg <= GW'(GENERATIONS - 1);
        end else if (w_pick) begin
            r_pe <= r_pg;
            if (r_pg != '0) begin
                r_pg <= r_pg - 1'b1;
            end
        end
        if (w_acc && (i_req.cmd == garm_pkg::CMD_INSERT)) begin
            r_rs_status <= w_ins_ok ? garm_pkg::ST_INSERTED : garm_pkg::ST_DROPPED;
            r_rs_code   <= '0;
            r_rs_offset <= '0;
            r_rs_gen    <= '0;
        end else if ((r_state == S_PICK) && r_pv) begin
            if (w_hit) begin
                r_rs_status <= garm_pkg::ST_HIT;
                r_rs_code   <= w_cand_data.code;
                r_rs_offset <= w_diff[SIZE_W-1:0];
                r_rs_gen    <= GEN_W'(r_pe);
            end else if (r_pe == '0) begin
                r_rs_status <= garm_pkg::ST_MISS;
                r_rs_code   <= '0;
                r_rs_offset <= '0;
                r_rs_gen    <= '0;
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_status <= r_rs_status;
            r_o_code   <= r_rs_code;
            r_o_offset <= r_rs_offset;
            r_o_gen    <= r_rs_gen;
        end
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.code      = r_o_code;
    assign o_rsp.offset    = r_o_offset;
    assign o_rsp.found_gen = r_o_gen;

endmodule

### sv/garm_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the generational address range map, bound to the top level.
// Depends on garm_pkg for the command and status codes.
module garm_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic                           i_req_cmd,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    input  logic [garm_pkg::ST_W-1:0]      i_rsp_status,
    input  logic [garm_pkg::CODE_W-1:0]    i_rsp_code,
    input  logic [garm_pkg::SIZE_W-1:0]    i_rsp_offset,
    input  logic [garm_pkg::GEN_W-1:0]     i_rsp_found_gen
);
    logic       w_req_acc;
    logic       w_rsp_acc;
    logic       r_head_cmd;
    logic       r_tail_cmd;
    logic [1:0] r_open;

    assign w_req_acc = i_req_valid && i_req_ready;
    assign w_rsp_acc = i_rsp_valid && i_rsp_ready;

    // At most two requests are open: one whose result waits at the output and one in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            case ({w_req_acc, w_rsp_acc})
                2'b10: begin
                    if (r_open == 2'd0) begin
                        r_head_cmd <= i_req_cmd;
                    end else begin
                        r_tail_cmd <= i_req_cmd;
                    end
                    r_open <= r_open + 2'd1;
                end
                2'b01: begin
                    r_head_cmd <= r_tail_cmd;
                    r_open     <= r_open - 2'd1;
                end
                2'b11: begin
                    if (r_open == 2'd1) begin
                        r_head_cmd <= i_req_cmd;
                    end else begin
                        r_head_cmd <= r_tail_cmd;
                        r_tail_cmd <= i_req_cmd;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // A shown result answers the oldest request that is still open.
    a_insert_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (r_head_cmd == garm_pkg::CMD_INSERT) |->
        (i_rsp_status == garm_pkg::ST_INSERTED) || (i_rsp_status == garm_pkg::ST_DROPPED))
        else $error("insert request answered with a lookup status");

    a_lookup_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (r_head_cmd == garm_pkg::CMD_LOOKUP) |->
        (i_rsp_status == garm_pkg::ST_HIT) || (i_rsp_status == garm_pkg::ST_MISS))
        else $error("lookup request answered with an insert status");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != garm_pkg::ST_HIT) |->
        (i_rsp_code == '0) && (i_rsp_offset == '0) && (i_rsp_found_gen == '0))
        else $error("result without a hit carries nonzero fields");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted while one is in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
        && $stable(i_rsp_code) && $stable(i_rsp_offset) && $stable(i_rsp_found_gen))
        else $error("stalled result changed");

endmodule

bind generational_address_range_map garm_chk u_garm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_cmd       (i_req.cmd),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_code      (o_rsp.code),
    .i_rsp_offset    (o_rsp.offset),
    .i_rsp_found_gen (o_rsp.found_gen)
);
